// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL of the combined LCG shuffle generator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on every rising edge of i_clk, ignored while i_rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Checked on every rising edge of i_clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: design/crng_pkg.sv
// ----------------------------------------------------------------------------
// crng_pkg
// Types, constants and the modular fold used by the combined LCG generator.
// ----------------------------------------------------------------------------
package crng_pkg;

    // Generator constants.
    localparam logic [30:0] MOD_ONE   = 31'd2147483563;
    localparam logic [30:0] MOD_TWO   = 31'd2147483399;
    localparam logic [15:0] MUL_ONE   = 16'd40014;
    localparam logic [15:0] MUL_TWO   = 16'd40692;
    // 2^31 mod MOD_ONE and 2^31 mod MOD_TWO.
    localparam logic [7:0]  FOLD_ONE  = 8'd85;
    localparam logic [7:0]  FOLD_TWO  = 8'd249;
    localparam logic [30:0] WRAP_TOP  = 31'd2147483562;
    localparam logic [30:0] Y_RESET   = 31'd123456789;
    localparam int          WARMUP_STEPS = 8;
    localparam int          PROD_W    = 47;

    // Configuration register index (paddr[2]).
    localparam logic        REG_SEED  = 1'b0;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED,
        S_FMUL,
        S_FRED,
        S_DMUL,
        S_DRED,
        S_DREAD,
        S_DFIN,
        S_PUSH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_seed;
        logic mul;
        logic upd_x;
        logic upd_y;
        logic fill_wr;
        logic set_out;
        logic pick_ld;
        logic rd;
        logic fin;
        logic push;
    } t_dp_cmd;

    // Reduces a 47-bit product modulo a modulus of the form 2^31 - fold.
    // The folded sum stays below twice the modulus, so one subtract suffices.
    function automatic logic [30:0] crng_fold(input logic [PROD_W-1:0] prod,
                                              input logic [7:0]        fold,
                                              input logic [30:0]       modulus);
        logic [31:0] sum;
        sum = {1'b0, prod[30:0]} + 32'(prod[PROD_W-1:31]) * 32'(fold);
        if (sum >= {1'b0, modulus}) begin
            sum = sum - {1'b0, modulus};
        end
        return sum[30:0];
    endfunction

endpackage

// File: design/combined_lcg_shuffle_rng.sv
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// Combined two-LCG uniform random generator with a Bays-Durham shuffle table.
//
// Usage: each transfer on the s_axis channel asks for one draw; tdata[0] is
// the reseed flag. With reseed set, both generators load from the seed
// register (zero is used as one), generator one runs 8 warm-up steps and
// TABLE_DEPTH fill steps, and then the draw follows. Each draw returns one
// 31-bit value in 1..2147483562 on m_axis; dividing by 2147483563 gives a
// fraction in (0,1). The seed register sits at APB address 0.
// Sequence: a plain draw runs from input transfer to output valid through
// the multiply step (which also captures the bucket of the previous output),
// the fold step, the registered table read, the finish step and the load of
// the output register. A reseed first adds a seed load and, for each
// generator one step, a multiply and a fold. One item is in flight at a time;
// s_axis_tready is high only when idle, so no new request is taken until
// the last result has been loaded into the output register.
// Reset: generators go to 1 and 123456789, the output to 0, the table reads
// as all zeros and the seed register to 1. When the receiver stalls, the
// result waits in the output register and the block may accept the next
// request; that draw's result waits until the output register empties.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng import crng_pkg::*; #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] reseed, [7:1] zero
    // Result channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [30:0] random_value, [31] zero
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [30:0]   r_seed;
    t_dp_cmd       cmd;
    logic [AW-1:0] fill_idx;
    logic          out_free;
    logic [30:0]   random_value;
    logic          r_tvalid;
    logic [30:0]   r_tvalue;

    // Configuration register.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 31'd1;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_SEED) begin
            r_seed <= pwdata[30:0];
        end
    end

    assign prdata = (paddr[2] == REG_SEED) ? {1'b0, r_seed} : '0;

    // Controller and datapath.
    crng_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_reseed   (s_axis_tdata[0]),
        .o_in_ready (s_axis_tready),
        .i_out_free (out_free),
        .o_cmd      (cmd),
        .o_fill_idx (fill_idx)
    );

    crng_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_fill_idx     (fill_idx),
        .i_seed         (r_seed),
        .o_random_value (random_value)
    );

    // Output register: loads when empty or emptied by this cycle's transfer.
    assign out_free = !r_tvalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
        end else if (cmd.push) begin
            r_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.push) begin
            r_tvalue <= random_value;
        end
    end

    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = {1'b0, r_tvalue};

endmodule

// File: design/crng_ram.sv
// ----------------------------------------------------------------------------
// crng_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crng_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/crng_datapath.sv
// ----------------------------------------------------------------------------
// crng_datapath
// Generator registers, modular multipliers, bucket select and shuffle table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crng_datapath import crng_pkg::*; #(
    parameter int TABLE_DEPTH = 32,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_cmd,
    input  logic [AW-1:0] i_fill_idx,
    input  logic [30:0]   i_seed,
    output logic [30:0]   o_random_value
);

    // Width of one table bucket in output values.
    localparam logic [30:0] BUCKET =
        31'(32'd1 + 32'(WRAP_TOP) / 32'(TABLE_DEPTH));

    logic [30:0]       r_x, n_x, r_y, n_y, r_out, n_out;
    logic [PROD_W-1:0] r_px, r_py;
    logic [30:0]       x_red, y_red, seed_eff;
    logic [AW-1:0]     pick_next;
    logic [AW-1:0]     r_pick;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [30:0]       ram_wdata, ram_rdata, entry;
    logic signed [32:0] diff;
    logic [30:0]       draw_value;

    // Modular reduction of the registered products.
    assign x_red    = crng_fold(r_px, FOLD_ONE, MOD_ONE);
    assign y_red    = crng_fold(r_py, FOLD_TWO, MOD_TWO);
    assign seed_eff = (i_seed == '0) ? 31'd1 : i_seed;

    // Products are registered before the fold.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_px <= PROD_W'(r_x) * PROD_W'(MUL_ONE);
            r_py <= PROD_W'(r_y) * PROD_W'(MUL_TWO);
        end
    end

    // Generator state.
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        if (i_cmd.load_seed) begin
            n_x = seed_eff;
            n_y = seed_eff;
        end
        if (i_cmd.upd_x) begin
            n_x = x_red;
        end
        if (i_cmd.upd_y) begin
            n_y = y_red;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= 31'd1;
            r_y <= Y_RESET;
        end else begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    // Bucket of the previous output: the highest bucket boundary at or below
    // it. Stopping at the last entry also saturates the index.
    always_comb begin
        pick_next = '0;
        for (int k = 1; k < TABLE_DEPTH; k++) begin
            if ({2'b00, r_out} >= 33'(k) * {2'b00, BUCKET}) begin
                pick_next = AW'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pick <= '0;
        end else if (i_cmd.pick_ld) begin
            r_pick <= pick_next;
        end
    end

    // Shuffle table write port: fill during reseed, replacement during a draw.
    assign ram_we    = i_cmd.fill_wr | i_cmd.fin;
    assign ram_waddr = i_cmd.fill_wr ? i_fill_idx : r_pick;
    assign ram_wdata = i_cmd.fill_wr ? x_red : r_x;

    crng_ram #(
        .WIDTH (31),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_pick),
        .o_rdata (ram_rdata)
    );

    // Entries never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (ram_we) begin
            r_valid[ram_waddr] <= 1'b1;
        end
    end

    assign entry = r_valid[r_pick] ? ram_rdata : '0;

    // New output: entry minus generator two, wrapped into 1..WRAP_TOP.
    always_comb begin
        diff = $signed({2'b00, entry}) - $signed({2'b00, r_y});
        if (diff < 33'sd1) begin
            diff = diff + $signed({2'b00, WRAP_TOP});
        end
        if (diff < 33'sd1) begin
            diff = 33'sd1;
        end
        if (diff > $signed({2'b00, WRAP_TOP})) begin
            diff = $signed({2'b00, WRAP_TOP});
        end
        draw_value = diff[30:0];
    end

    // Shuffle output register.
    always_comb begin
        n_out = r_out;
        if (i_cmd.set_out) begin
            n_out = x_red;
        end
        if (i_cmd.fin) begin
            n_out = draw_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else begin
            r_out <= n_out;
        end
    end

    assign o_random_value = r_out;

    // A finished draw leaves the output inside its range.
    `ASSERT_CLK(a_out_range, $past(i_cmd.fin) |-> (r_out >= 31'd1 && r_out <= WRAP_TOP),
                "draw result out of range")
    // A generator one step leaves the state reduced below its modulus.
    `ASSERT_CLK(a_x_reduced, $past(i_cmd.upd_x) |-> (r_x < MOD_ONE),
                "generator one not reduced")
    // A generator two step leaves the state reduced below its modulus.
    `ASSERT_CLK(a_y_reduced, $past(i_cmd.upd_y) |-> (r_y < MOD_TWO),
                "generator two not reduced")

endmodule

// File: design/crng_ctrl.sv
// ----------------------------------------------------------------------------
// crng_ctrl
// Sequencer for reseed fill and draw steps of the combined LCG generator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crng_ctrl import crng_pkg::*; #(
    parameter int TABLE_DEPTH = 32,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + WARMUP_STEPS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_reseed,
    output logic          o_in_ready,
    input  logic          i_out_free,
    output t_dp_cmd       o_cmd,
    output logic [AW-1:0] o_fill_idx
);

    t_state         r_state, n_state;
    logic [CW-1:0]  r_cnt, n_cnt;

    // Next state and step counter. The counter holds the fill position,
    // counting down to entry zero.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_reseed ? S_SEED : S_DMUL;
                end
            end
            S_SEED: begin
                n_cnt   = CW'(TABLE_DEPTH + WARMUP_STEPS - 1);
                n_state = S_FMUL;
            end
            S_FMUL: begin
                n_state = S_FRED;
            end
            S_FRED: begin
                if (r_cnt == '0) begin
                    n_state = S_DMUL;
                end else begin
                    n_cnt   = r_cnt - CW'(1);
                    n_state = S_FMUL;
                end
            end
            S_DMUL: begin
                n_state = S_DRED;
            end
            S_DRED: begin
                n_state = S_DREAD;
            end
            S_DREAD: begin
                n_state = S_DFIN;
            end
            S_DFIN: begin
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Commands decoded from the state.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_SEED: begin
                o_cmd.load_seed = 1'b1;
            end
            S_FMUL: begin
                o_cmd.mul = 1'b1;
            end
            S_FRED: begin
                o_cmd.upd_x   = 1'b1;
                o_cmd.fill_wr = (r_cnt < CW'(TABLE_DEPTH));
                o_cmd.set_out = (r_cnt == '0);
            end
            S_DMUL: begin
                o_cmd.mul     = 1'b1;
                o_cmd.pick_ld = 1'b1;
            end
            S_DRED: begin
                o_cmd.upd_x = 1'b1;
                o_cmd.upd_y = 1'b1;
            end
            S_DREAD: begin
                o_cmd.rd = 1'b1;
            end
            S_DFIN: begin
                o_cmd.fin = 1'b1;
            end
            S_PUSH: begin
                o_cmd.push = i_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_fill_idx = r_cnt[AW-1:0];

    // The table index is captured only in the draw multiply step.
    `ASSERT_CLK(a_pick_with_mul, o_cmd.pick_ld |-> o_cmd.mul,
                "table index captured outside the draw multiply")
    // Every table read is followed by the draw finish.
    `ASSERT_CLK(a_rd_then_fin, o_cmd.rd |=> o_cmd.fin,
                "table read not followed by the draw finish")
    // A result is pushed only into a free output register.
    `ASSERT_CLK(a_push_free, o_cmd.push |-> i_out_free,
                "result pushed into a full output register")

endmodule

// File: dv/combined_lcg_shuffle_rng_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_test
// Self-checking bench for the combined two-LCG generator with shuffle table.
//
// A queue of draw requests feeds a clocked driver on the request stream.
// A clocked monitor predicts each accepted draw with a local copy of both
// generators, the shuffle table and the seed register, and it compares every
// result transfer against the oldest prediction. The run covers draws from
// the reset state, extreme seeds and random traffic under several idling
// patterns, plus a long receiver hold-off.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng_test import crng_pkg::*;;

    localparam int          SHUFFLE_DEPTH = 32;
    localparam logic [30:0] BUCKET_SIZE   = 31'(1 + WRAP_TOP / SHUFFLE_DEPTH);
    localparam logic [2:0]  SEED_ADDR     = {REG_SEED, 2'b00};
    localparam logic [2:0]  UNUSED_ADDR   = 3'd4;
    localparam int          SETTLE_CYCLES = 120;
    localparam int          RANDOM_ITEMS  = 100;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata   = 8'd0;   // [0] reseed, [7:1] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [31:0] m_axis_tdata;            // [30:0] random_value, [31] zero
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [2:0]  paddr          = 3'd0;
    logic [31:0] pwdata         = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state.
    logic [30:0] seed_reg;
    logic [30:0] gen_one;
    logic [30:0] gen_two;
    logic [30:0] shuf_out;
    logic [30:0] shuf_tab [SHUFFLE_DEPTH];

    bit          pending_reqs [$];
    logic [30:0] expected_values [$];
    bit          req_taken;
    int          send_idle_pct;
    int          rx_stall_pct;
    int          rx_hold_left;
    int          error_count;
    int          draws_checked;
    int          reseeds_sent;
    int          reg_writes;

    combined_lcg_shuffle_rng #(
        .TABLE_DEPTH(SHUFFLE_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit, far beyond a run where every draw reseeds and stalls long.
    initial begin
        #5_000_000;
        $display("combined_lcg_shuffle_rng_test: errors");
        $finish;
    end

    function automatic logic [30:0] lcg_one_next(input logic [30:0] x);
        logic [63:0] prod;
        prod = 64'(MUL_ONE) * 64'(x);
        return 31'(prod % 64'(MOD_ONE));
    endfunction

    function automatic logic [30:0] lcg_two_next(input logic [30:0] y);
        logic [63:0] prod;
        prod = 64'(MUL_TWO) * 64'(y);
        return 31'(prod % 64'(MOD_TWO));
    endfunction

    function automatic void predictor_reset();
        seed_reg = 31'd1;
        gen_one  = 31'd1;
        gen_two  = Y_RESET;
        shuf_out = 31'd0;
        for (int n = 0; n < SHUFFLE_DEPTH; n++) begin
            shuf_tab[n] = 31'd0;
        end
    endfunction

    // Predicts one draw, reseeding first when asked.
    function automatic logic [30:0] shuffle_draw(input bit reseed);
        logic [30:0] s;
        int          pick;
        longint      diff;
        if (reseed) begin
            s = (seed_reg == 31'd0) ? 31'd1 : seed_reg;
            gen_two = s;
            // Eight warm-up steps, then the table fills from the top index down.
            for (int n = SHUFFLE_DEPTH + 7; n >= 0; n--) begin
                s = lcg_one_next(s);
                if (n < SHUFFLE_DEPTH) begin
                    shuf_tab[n] = s;
                end
            end
            gen_one  = s;
            shuf_out = shuf_tab[0];
        end
        gen_one = lcg_one_next(gen_one);
        gen_two = lcg_two_next(gen_two);
        pick = int'(shuf_out / BUCKET_SIZE);
        if (pick >= SHUFFLE_DEPTH) begin
            pick = SHUFFLE_DEPTH - 1;
        end
        diff = longint'(shuf_tab[pick]) - longint'(gen_two);
        shuf_tab[pick] = gen_one;
        if (diff < 1) begin
            diff += longint'(WRAP_TOP);
        end
        if (diff < 1) begin
            diff = 1;
        end
        if (diff > longint'(WRAP_TOP)) begin
            diff = longint'(WRAP_TOP);
        end
        shuf_out = 31'(diff);
        return shuf_out;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Request driver: a new item goes out only once the last one transferred.
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || req_taken)) begin
            req_taken = 1'b0;
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'd0, pending_reqs.pop_front()};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: a counted hold-off takes priority over random stalls.
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Monitor: predict on each request transfer, check each result transfer.
    always @(posedge i_clk) begin
        logic [30:0] want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_values.push_back(shuffle_draw(s_axis_tdata[0]));
                reseeds_sent += s_axis_tdata[0];
                req_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_values.size() == 0) begin
                    report_mismatch("result with nothing expected", m_axis_tdata, 32'd0);
                end else begin
                    want = expected_values.pop_front();
                    if (m_axis_tdata !== {1'b0, want}) begin
                        report_mismatch("random_value", m_axis_tdata, {1'b0, want});
                    end
                    draws_checked++;
                end
            end
        end
    end

    // Waits until every queued request has gone out and every result came back.
    // Checked at the rising edge, where the driven request signals are settled.
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_values.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // Writes one register, then reads the seed register back.
    task automatic apb_write_and_check(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == SEED_ADDR) begin
            seed_reg = data[30:0];
        end
        reg_writes++;
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= SEED_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[30:0] !== seed_reg) begin
            report_mismatch("seed register read-back", {1'b0, prdata[30:0]},
                            {1'b0, seed_reg});
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Queues a run of draws; the first one may force a reseed.
    task automatic queue_draws(input int count, input bit lead_reseed, input int reseed_pct);
        for (int n = 0; n < count; n++) begin
            if (n == 0) begin
                pending_reqs.push_back(lead_reseed);
            end else begin
                pending_reqs.push_back($urandom_range(99) < reseed_pct);
            end
        end
    endtask

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(11))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return {1'b0, MOD_ONE};
            3:       return {1'b0, MOD_TWO};
            4:       return 32'h7FFF_FFFF;
            5:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic set_idle_mode(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  rx_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 81; rx_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  rx_stall_pct = 81; end
            default:       begin send_idle_pct = 18; rx_stall_pct = 18; end
        endcase
    endtask

    // Main sequence.
    initial begin
        int guard;
        error_count   = 0;
        draws_checked = 0;
        reseeds_sent  = 0;
        reg_writes    = 0;
        req_taken     = 1'b0;
        rx_hold_left  = 0;
        set_idle_mode(IDLE_NONE);
        predictor_reset();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Draws straight from the reset state, before any reseed.
        pending_reqs = '{1'b0, 1'b0, 1'b0};
        wait_drained();
        // Reseed from the reset value of the seed register.
        pending_reqs = '{1'b1, 1'b0};
        wait_drained();
        // A zero seed behaves as one.
        apb_write_and_check(SEED_ADDR, 32'd0);
        pending_reqs = '{1'b1, 1'b0, 1'b0};
        wait_drained();
        // Largest seed the register holds.
        apb_write_and_check(SEED_ADDR, 32'h7FFF_FFFF);
        pending_reqs = '{1'b1, 1'b0};
        wait_drained();
        // Seeds equal to each modulus leave that generator stuck at zero.
        apb_write_and_check(SEED_ADDR, {1'b0, MOD_ONE});
        pending_reqs = '{1'b1, 1'b0, 1'b0};
        wait_drained();
        apb_write_and_check(SEED_ADDR, {1'b0, MOD_TWO});
        pending_reqs = '{1'b1, 1'b0, 1'b0};
        wait_drained();
        // A write past the last register changes nothing.
        apb_write_and_check(UNUSED_ADDR, 32'h1234_5678);
        pending_reqs = '{1'b1, 1'b0};
        wait_drained();

        // Random traffic under each idling pattern, with a new seed per segment.
        for (int m = 0; m < 4; m++) begin
            set_idle_mode(t_idle_mode'(m));
            for (int seg = 0; seg < 2; seg++) begin
                if (seg == 0) begin
                    apb_write_and_check(UNUSED_ADDR, $urandom());
                end
                apb_write_and_check(SEED_ADDR, pick_seed());
                queue_draws(RANDOM_ITEMS, $urandom_range(7) != 0, 6);
                wait_drained();
            end
        end

        // Long receiver hold-off while the sender keeps offering requests.
        set_idle_mode(IDLE_NONE);
        apb_write_and_check(SEED_ADDR, pick_seed());
        @(posedge i_clk);
        rx_hold_left = 400;
        queue_draws(40, 1'b1, 5);
        wait_drained();

        // Final drain with its own limit.
        guard = 0;
        while ((pending_reqs.size() != 0 || s_axis_tvalid || expected_values.size() != 0)
               && guard < 20000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_values.size() != 0) begin
            report_mismatch("results never delivered", 32'(expected_values.size()), 32'd0);
        end

        $display("Checked %0d draws (%0d reseeding) after %0d register writes,",
                 draws_checked, reseeds_sent, reg_writes);
        $display("over four idling patterns and one long receiver hold-off.");
        if (error_count == 0) begin
            $display("combined_lcg_shuffle_rng_test: clean");
        end else begin
            $display("combined_lcg_shuffle_rng_test: errors");
        end
        $finish;
    end

endmodule

// File: combined_lcg_shuffle_rng.f
+incdir+design
design/crng_pkg.sv
design/crng_ram.sv
design/crng_datapath.sv
design/crng_ctrl.sv
design/combined_lcg_shuffle_rng.sv
dv/combined_lcg_shuffle_rng_test.sv
